@@ sv/brlq_pkg.sv @@
// ----------------------------------------------------------------------------
// brlq_pkg: shared types and constants for the byte rate limiter queue
// Field widths, command and verdict codes, register indexes and the
// fixed-point constants of the per-tick budget (divide by 1000, half up).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brlq_pkg;

    // Default sizes handed to the top level parameters
    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int REQUESTER_BITS_DEF = 8;

    // Grants one tick may produce
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int DATA_W    = 32;
    localparam int ID_W      = 8;
    localparam int KIND_W    = 2;
    localparam int VERDICT_W = 2;
    localparam int ELAPSED_W = 16;
    localparam int CFG_IDX_W = 1;

    // Budget arithmetic: elapsed_ms * max_rate fits 48 bits, then / 1000
    localparam int PROD_W     = ELAPSED_W + DATA_W;
    localparam int DIVISOR    = 1000;
    localparam int ROUND_BIAS = DIVISOR / 2;
    localparam int REM_W      = $clog2(DIVISOR);

    // Divider digits: 16 quotient bits per step from a 26-bit partial
    // dividend, found by multiplying with ceil(2^36 / 1000)
    localparam int CHUNK_W     = 16;
    localparam int CHUNKS      = PROD_W / CHUNK_W;
    localparam int PART_W      = REM_W + CHUNK_W;
    localparam int RECIP_SHIFT = PART_W + REM_W;
    localparam int RECIP_W     = 27;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));
    localparam int STEP_W      = $clog2(CHUNKS);

    // Command codes
    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_KILL    = 2'd2;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_ALLOWED  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_QUEUED   = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_REJECTED = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_GRANT    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARE    = 1'b1;

endpackage

@@ sv/brlq_div.sv @@
// ----------------------------------------------------------------------------
// brlq_div: divider by the constant 1000
// Produces the quotient 16 bits at a time: each digit comes from a reciprocal
// multiply of remainder and next dividend chunk, followed by a retire step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brlq_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [brlq_pkg::PROD_W-1:0]  dividend,
    output logic                         done,
    output logic [brlq_pkg::PROD_W-1:0]  quotient
);
    import brlq_pkg::*;

    localparam int RPROD_W = PART_W + RECIP_W;

    logic [PROD_W-1:0]  work_reg;
    logic [PROD_W-1:0]  work_next;
    logic [REM_W-1:0]   rem_reg;
    logic [REM_W-1:0]   rem_next;
    logic [RPROD_W-1:0] scaled_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               run_reg;
    logic               phase_reg;
    logic               done_reg;
    logic [PART_W-1:0]  part;
    logic [CHUNK_W-1:0] digit;
    logic [PART_W-1:0]  digit_back;

    // Form the partial dividend and split off one quotient digit
    always_comb
    begin
        part       = {rem_reg, work_reg[PROD_W-1 -: CHUNK_W]};
        digit      = scaled_reg[RECIP_SHIFT +: CHUNK_W];
        digit_back = PART_W'(digit) * PART_W'(DIVISOR);
        rem_next   = REM_W'(part - digit_back);
        work_next  = {work_reg[PROD_W-CHUNK_W-1:0], digit};
    end

    // Sequence the digits: multiply, then retire
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            phase_reg <= 1'b0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg   <= 1'b1;
                phase_reg <= 1'b0;
                step_reg  <= '0;
            end
            else if (run_reg)
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(CHUNKS - 1))
                    begin
                        run_reg  <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Hold the working word, remainder and scaled partial dividend
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
        end
        else if (run_reg && !phase_reg)
        begin
            scaled_reg <= RPROD_W'(part) * RPROD_W'(RECIP);
        end
        else if (run_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

@@ sv/brlq_mem.sv @@
// ----------------------------------------------------------------------------
// brlq_mem: storage of the pending request queue
// One write port and one read port with registered read data; holds the
// requester and the remaining byte count of each queued word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brlq_mem #(
    parameter int DEPTH = brlq_pkg::QUEUE_DEPTH_DEF,
    parameter int OWN_W = brlq_pkg::ID_W
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [OWN_W-1:0]             wr_owner,
    input  logic [brlq_pkg::DATA_W-1:0]  wr_bytes,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [OWN_W-1:0]             rd_owner,
    output logic [brlq_pkg::DATA_W-1:0]  rd_bytes
);
    import brlq_pkg::*;

    logic [OWN_W-1:0]  owner_mem [DEPTH];
    logic [DATA_W-1:0] bytes_mem [DEPTH];

    // Write one word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            owner_mem[wr_addr] <= wr_owner;
            bytes_mem[wr_addr] <= wr_bytes;
        end
    end

    // Register the read word
    always_ff @(posedge clk)
    begin
        rd_owner <= owner_mem[rd_addr];
        rd_bytes <= bytes_mem[rd_addr];
    end

endmodule

@@ sv/byte_rate_limiter_queue_core.sv @@
// ----------------------------------------------------------------------------
// byte_rate_limiter_queue_core: byte-rate limiter with a pending request queue
// Passes, queues or rejects send requests, hands out a per-tick byte budget
// to queued requests in order, and removes the words of a killed requester.
//
// Usage:
//   Commands enter on start/kind/requester/byte_count/current_rate/elapsed_ms
//   and are taken at an edge where start is high and busy is low. Results
//   leave on result_valid with verdict/granted_to/granted_bytes/last, one
//   cycle each; the receiver cannot stall them, and last marks the final
//   result of a command. max_rate and share_check_enable are written on the
//   cfg_valid/cfg_ready channel (cfg_ready is always high), while idle; the
//   user must keep to this, as the block itself does not enforce it.
// Steps after the accepting edge:
//   Request: busy in S_REQ only, result on the ports the cycle after.
//   Tick: product in S_TICK, launch in S_MUL, the divider by 1000 in S_DIV
//     (three reciprocal-multiply digit steps, then a hand-over), then a
//     queue read (S_GRD) and a decision (S_GRP) per grant.
//     With max_rate zero the divider is skipped. At most 16 grants per tick.
//   Kill: a read (S_KRD) and a compaction step (S_KPR) per queued word, then a
//     final S_KRD; no result. Unknown command: taken and dropped, not busy.
// Reset clears the state and configuration registers, the queue pointers and
// the carried budget, but no payload register; queue storage needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_rate_limiter_queue_core #(
    parameter int QUEUE_DEPTH    = brlq_pkg::QUEUE_DEPTH_DEF,
    parameter int REQUESTER_BITS = brlq_pkg::REQUESTER_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // command channel
    input  logic                            start,
    output logic                            busy,
    input  logic [brlq_pkg::KIND_W-1:0]     kind,
    input  logic [brlq_pkg::ID_W-1:0]       requester,
    input  logic [brlq_pkg::DATA_W-1:0]     byte_count,
    input  logic [brlq_pkg::DATA_W-1:0]     current_rate,
    input  logic [brlq_pkg::ELAPSED_W-1:0]  elapsed_ms,
    // result channel
    output logic                            result_valid,
    output logic [brlq_pkg::VERDICT_W-1:0]  verdict,
    output logic [brlq_pkg::ID_W-1:0]       granted_to,
    output logic [brlq_pkg::DATA_W-1:0]     granted_bytes,
    output logic                            last,
    // configuration channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [brlq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [brlq_pkg::DATA_W-1:0]     cfg_data
);
    import brlq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OWN_W = (REQUESTER_BITS < ID_W) ? REQUESTER_BITS : ID_W;

    // State codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_REQ  = 4'd1;
    localparam logic [3:0] S_TICK = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_GRD  = 4'd5;
    localparam logic [3:0] S_GRP  = 4'd6;
    localparam logic [3:0] S_KRD  = 4'd7;
    localparam logic [3:0] S_KPR  = 4'd8;

    // Modular add of an offset below the depth onto a queue pointer
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                  input logic [FILL_W-1:0] off);
        logic [FILL_W:0] sum;
        sum = (FILL_W+1)'(base) + (FILL_W+1)'(off);
        if (sum >= (FILL_W+1)'(QUEUE_DEPTH))
            sum = sum - (FILL_W+1)'(QUEUE_DEPTH);
        return sum[PTR_W-1:0];
    endfunction

    logic [3:0]           state_reg, state_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [DATA_W-1:0]    carry_reg, carry_next;
    logic [DATA_W-1:0]    budget_reg, budget_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic                 zero_reg, zero_next;
    logic [FILL_W-1:0]    idx_reg, idx_next;
    logic [FILL_W-1:0]    keep_reg, keep_next;

    logic [DATA_W-1:0]    max_rate_reg;
    logic                 share_reg;

    logic [OWN_W-1:0]     who_reg;
    logic [DATA_W-1:0]    bytes_reg;
    logic [DATA_W-1:0]    cur_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [PROD_W-1:0]    prod_reg;

    logic                 rv_reg, rv_next;
    logic [VERDICT_W-1:0] verdict_reg, verdict_next;
    logic [ID_W-1:0]      to_reg, to_next;
    logic [DATA_W-1:0]    out_bytes_reg, out_bytes_next;
    logic                 last_reg, last_next;

    logic                 accept;
    logic                 div_start;
    logic                 div_done;
    logic [PROD_W-1:0]    quot;
    logic [DATA_W:0]      sat_sum;
    logic [DATA_W-1:0]    new_budget;
    logic [DATA_W+1:0]    cur4;
    logic [DATA_W+1:0]    max3;
    logic                 pass;
    logic                 fits;
    logic [DATA_W-1:0]    spent;
    logic                 ends_here;

    logic                 wr_en;
    logic [PTR_W-1:0]     wr_addr;
    logic [OWN_W-1:0]     wr_owner;
    logic [DATA_W-1:0]    wr_bytes;
    logic [PTR_W-1:0]     rd_addr;
    logic [OWN_W-1:0]     rd_owner;
    logic [DATA_W-1:0]    rd_bytes;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign div_start = (state_reg == S_MUL);

    // Queue storage
    brlq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .OWN_W (OWN_W)
    ) u_mem (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_owner (wr_owner),
        .wr_bytes (wr_bytes),
        .rd_addr  (rd_addr),
        .rd_owner (rd_owner),
        .rd_bytes (rd_bytes)
    );

    // Divider for round(product / 1000)
    brlq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg + PROD_W'(ROUND_BIAS)),
        .done     (div_done),
        .quotient (quot)
    );

    // Pass rule: max_rate zero, or share check on and 4 * current_rate < 3 * max_rate
    always_comb
    begin
        cur4 = {cur_reg, 2'b00};
        max3 = {2'b00, max_rate_reg} + {1'b0, max_rate_reg, 1'b0};
        pass = (max_rate_reg == '0) || (share_reg && (cur4 < max3));
    end

    // Saturate quotient plus carried budget to 32 bits
    always_comb
    begin
        sat_sum    = {1'b0, quot[DATA_W-1:0]} + {1'b0, carry_reg};
        new_budget = ((|quot[PROD_W-1:DATA_W]) || sat_sum[DATA_W]) ? '1
                                                                   : sat_sum[DATA_W-1:0];
    end

    // Grant decision on the head word
    always_comb
    begin
        fits  = (rd_bytes <= budget_reg);
        spent = budget_reg - rd_bytes;
    end

    // Queue read address
    always_comb
    begin
        if (state_reg == S_KRD)
            rd_addr = wrap_add(head_reg, idx_reg);
        else
            rd_addr = head_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        carry_next     = carry_reg;
        budget_next    = budget_reg;
        n_next         = n_reg;
        zero_next      = zero_reg;
        idx_next       = idx_reg;
        keep_next      = keep_reg;
        rv_next        = 1'b0;
        verdict_next   = verdict_reg;
        to_next        = to_reg;
        out_bytes_next = out_bytes_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = head_reg;
        wr_owner       = rd_owner;
        wr_bytes       = rd_bytes;
        ends_here      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        KIND_REQUEST: state_next = S_REQ;
                        KIND_TICK:    state_next = S_TICK;
                        KIND_KILL:
                        begin
                            idx_next   = '0;
                            keep_next  = '0;
                            state_next = S_KRD;
                        end
                        default:      state_next = S_IDLE;
                    endcase
                end
            end

            S_REQ:
            begin
                rv_next        = 1'b1;
                to_next        = ID_W'(who_reg);
                last_next      = 1'b1;
                out_bytes_next = '0;
                if (pass)
                begin
                    verdict_next   = VERDICT_ALLOWED;
                    out_bytes_next = bytes_reg;
                end
                else if (fill_reg == FILL_W'(QUEUE_DEPTH))
                begin
                    verdict_next = VERDICT_REJECTED;
                end
                else
                begin
                    verdict_next = VERDICT_QUEUED;
                    wr_en        = 1'b1;
                    wr_addr      = wrap_add(head_reg, fill_reg);
                    wr_owner     = who_reg;
                    wr_bytes     = bytes_reg;
                    fill_next    = fill_reg + 1'b1;
                end
                state_next = S_IDLE;
            end

            S_TICK:
            begin
                n_next = '0;
                if (max_rate_reg == '0)
                begin
                    carry_next = '0;
                    zero_next  = 1'b1;
                    state_next = (fill_reg == '0) ? S_IDLE : S_GRD;
                end
                else
                begin
                    state_next = (fill_reg == '0) ? S_IDLE : S_MUL;
                end
            end

            S_MUL:
            begin
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    carry_next  = '0;
                    budget_next = new_budget;
                    zero_next   = 1'b0;
                    state_next  = (new_budget == '0) ? S_IDLE : S_GRD;
                end
            end

            S_GRD:
            begin
                state_next = S_GRP;
            end

            S_GRP:
            begin
                rv_next      = 1'b1;
                verdict_next = VERDICT_GRANT;
                to_next      = ID_W'(rd_owner);
                n_next       = n_reg + 1'b1;
                if (zero_reg || fits)
                begin
                    // release the head word
                    out_bytes_next = zero_reg ? '0 : rd_bytes;
                    head_next      = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                           : head_reg + 1'b1;
                    fill_next      = fill_reg - 1'b1;
                    if (!zero_reg)
                        budget_next = spent;
                    ends_here = (fill_reg == FILL_W'(1)) ||
                                (!zero_reg && (spent == '0)) ||
                                (n_reg == CNT_W'(MAX_RESULTS - 1));
                end
                else
                begin
                    // serve part of the head word and keep its remainder
                    out_bytes_next = budget_reg;
                    wr_en          = 1'b1;
                    wr_addr        = head_reg;
                    wr_owner       = rd_owner;
                    wr_bytes       = rd_bytes - budget_reg;
                    budget_next    = '0;
                    ends_here      = 1'b1;
                end
                last_next = ends_here;
                if (ends_here)
                begin
                    if (!zero_reg)
                        carry_next = budget_next;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_GRD;
                end
            end

            S_KRD:
            begin
                if (idx_reg == fill_reg)
                begin
                    fill_next  = keep_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_KPR;
                end
            end

            S_KPR:
            begin
                // compact surviving words toward the head
                if (rd_owner != who_reg)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = wrap_add(head_reg, keep_reg);
                    keep_next = keep_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_KRD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            carry_reg <= '0;
            n_reg     <= '0;
            zero_reg  <= 1'b0;
            idx_reg   <= '0;
            keep_reg  <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            carry_reg <= carry_next;
            n_reg     <= n_next;
            zero_reg  <= zero_next;
            idx_reg   <= idx_next;
            keep_reg  <= keep_next;
            rv_reg    <= rv_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rate_reg <= '0;
            share_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAX_RATE: max_rate_reg <= cfg_data;
                CFG_SHARE:    share_reg    <= cfg_data[0];
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            who_reg     <= requester[OWN_W-1:0];
            bytes_reg   <= byte_count;
            cur_reg     <= current_rate;
            elapsed_reg <= elapsed_ms;
        end
        if (state_reg == S_TICK)
            prod_reg <= PROD_W'(elapsed_reg) * PROD_W'(max_rate_reg);
        budget_reg    <= budget_next;
        verdict_reg   <= verdict_next;
        to_reg        <= to_next;
        out_bytes_reg <= out_bytes_next;
        last_reg      <= last_next;
    end

    assign result_valid  = rv_reg;
    assign verdict       = verdict_reg;
    assign granted_to    = to_reg;
    assign granted_bytes = out_bytes_reg;
    assign last          = last_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("result pending but sequencer idle");

    a_req_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_REQUEST) |=> busy ##1 (result_valid && last))
        else $error("request result not delivered on time");

    a_single_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && verdict != VERDICT_GRANT) |-> last)
        else $error("request verdict not marked last");
`endif

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for byte_rate_limiter_queue_core
// Drives command words from a backlog with random gaps, none in one phase,
// and keeps its own model of the pending queue and the carried budget. Each
// result is compared field by field with the oldest predicted one. Register
// settings change between phases, only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import brlq_pkg::*;

    localparam int QDEPTH = QUEUE_DEPTH_DEF;
    // The package has no name for the unused command code
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    // Longest silent work: a kill walks the whole queue without a result
    localparam int SETTLE_CYCLES = 120;
    localparam int PHASE_WORDS   = 41;
    localparam int PHASE_COUNT   = 8;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [ID_W-1:0]      requester;
        logic [DATA_W-1:0]    byte_count;
        logic [DATA_W-1:0]    current_rate;
        logic [ELAPSED_W-1:0] elapsed_ms;
    } command_t;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [ID_W-1:0]      who;
        logic [DATA_W-1:0]    bytes;
        logic                 last;
    } verdict_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic     start    = 1'b0;
    command_t cmd_word = '0;
    logic     busy;

    logic                 result_valid;
    logic [VERDICT_W-1:0] verdict;
    logic [ID_W-1:0]      granted_to;
    logic [DATA_W-1:0]    granted_bytes;
    logic                 last;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;

    // Backlog of words to send and results still owed by the block
    command_t command_backlog[$];
    verdict_t verdicts_due[$];
    int       idle_pct = 21;

    // Model copy of the registers and the queue
    logic [DATA_W-1:0] limit_rate = '0;
    logic              share_on   = 1'b0;
    logic [ID_W-1:0]   slot_owner [QDEPTH];
    logic [DATA_W-1:0] slot_bytes [QDEPTH];
    int                slot_head  = 0;
    int                slot_fill  = 0;
    logic [DATA_W-1:0] carried    = '0;

    int mismatch_count  = 0;
    int commands_taken  = 0;
    int results_checked = 0;
    int grants_checked  = 0;
    int settings_used   = 0;

    byte_rate_limiter_queue_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (cmd_word.kind),
        .requester     (cmd_word.requester),
        .byte_count    (cmd_word.byte_count),
        .current_rate  (cmd_word.current_rate),
        .elapsed_ms    (cmd_word.elapsed_ms),
        .result_valid  (result_valid),
        .verdict       (verdict),
        .granted_to    (granted_to),
        .granted_bytes (granted_bytes),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic verdict_t make_verdict(logic [VERDICT_W-1:0] v, logic [ID_W-1:0] who,
                                              logic [DATA_W-1:0] bytes);
        verdict_t r;
        r.verdict = v;
        r.who     = who;
        r.bytes   = bytes;
        r.last    = 1'b0;
        return r;
    endfunction

    // Advance the model by one accepted word and queue up its results
    function automatic void apply_command(command_t c);
        verdict_t          outs [MAX_RESULTS];
        int                n;
        int                keep;
        int                src;
        int                dst;
        logic              pass;
        logic [63:0]       product;
        logic [63:0]       budget;
        logic [DATA_W-1:0] want;
        n = 0;
        case (c.kind)
            KIND_REQUEST:
            begin
                pass = (limit_rate == '0) ||
                       (share_on && ({32'b0, c.current_rate} * 4 < {32'b0, limit_rate} * 3));
                if (pass)
                begin
                    outs[0] = make_verdict(VERDICT_ALLOWED, c.requester, c.byte_count);
                end
                else if (slot_fill >= QDEPTH)
                begin
                    outs[0] = make_verdict(VERDICT_REJECTED, c.requester, '0);
                end
                else
                begin
                    dst = (slot_head + slot_fill) % QDEPTH;
                    slot_owner[dst] = c.requester;
                    slot_bytes[dst] = c.byte_count;
                    slot_fill++;
                    outs[0] = make_verdict(VERDICT_QUEUED, c.requester, '0);
                end
                n = 1;
            end
            KIND_TICK:
            begin
                if (limit_rate == '0)
                begin
                    // Unlimited rate: release everything with a zero grant
                    while (slot_fill > 0 && n < MAX_RESULTS)
                    begin
                        outs[n] = make_verdict(VERDICT_GRANT, slot_owner[slot_head], '0);
                        n++;
                        slot_head = (slot_head + 1) % QDEPTH;
                        slot_fill--;
                    end
                    carried = '0;
                end
                else if (slot_fill > 0)
                begin
                    product = {48'b0, c.elapsed_ms} * {32'b0, limit_rate};
                    budget  = (product + ROUND_BIAS) / DIVISOR + {32'b0, carried};
                    if (budget > 64'hFFFF_FFFF)
                        budget = 64'hFFFF_FFFF;
                    while (slot_fill > 0 && budget != 0 && n < MAX_RESULTS)
                    begin
                        want = slot_bytes[slot_head];
                        if ({32'b0, want} <= budget)
                        begin
                            budget  = budget - {32'b0, want};
                            outs[n] = make_verdict(VERDICT_GRANT, slot_owner[slot_head], want);
                            slot_head = (slot_head + 1) % QDEPTH;
                            slot_fill--;
                        end
                        else
                        begin
                            // Partial grant: the head keeps its remainder
                            outs[n] = make_verdict(VERDICT_GRANT, slot_owner[slot_head],
                                                   budget[31:0]);
                            slot_bytes[slot_head] = want - budget[31:0];
                            budget = 0;
                        end
                        n++;
                    end
                    carried = budget[31:0];
                end
            end
            KIND_KILL:
            begin
                // Compact the queue, dropping the killed requester's words
                keep = 0;
                for (int i = 0; i < slot_fill; i++)
                begin
                    src = (slot_head + i) % QDEPTH;
                    if (slot_owner[src] != c.requester)
                    begin
                        dst = (slot_head + keep) % QDEPTH;
                        slot_owner[dst] = slot_owner[src];
                        slot_bytes[dst] = slot_bytes[src];
                        keep++;
                    end
                end
                slot_fill = keep;
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                outs[i].last = 1'b1;
            verdicts_due.push_back(outs[i]);
        end
    endfunction

    function automatic command_t request_cmd(logic [ID_W-1:0] id, logic [DATA_W-1:0] bytes,
                                             logic [DATA_W-1:0] rate);
        command_t c;
        c = '0;
        c.kind         = KIND_REQUEST;
        c.requester    = id;
        c.byte_count   = bytes;
        c.current_rate = rate;
        return c;
    endfunction

    function automatic command_t tick_cmd(logic [ELAPSED_W-1:0] ms);
        command_t c;
        c = '0;
        c.kind       = KIND_TICK;
        c.elapsed_ms = ms;
        return c;
    endfunction

    function automatic command_t kill_cmd(logic [ID_W-1:0] id);
        command_t c;
        c = '0;
        c.kind      = KIND_KILL;
        c.requester = id;
        return c;
    endfunction

    // Random word: mostly requests and ticks from a small requester pool
    function automatic command_t random_command();
        command_t c;
        int       pick;
        c.requester = ($urandom_range(3) == 0) ? ID_W'($urandom_range(255))
                                               : ID_W'($urandom_range(7));
        case ($urandom_range(9))
            0:       c.byte_count = '0;
            1:       c.byte_count = 32'hFFFF_FFFF;
            2, 3:    c.byte_count = $urandom;
            4, 5:    c.byte_count = $urandom_range(2000);
            default: c.byte_count = $urandom_range(300);
        endcase
        if ($urandom_range(1) == 1 && limit_rate != '0)
            c.current_rate = $urandom_range(limit_rate, 0);
        else
            c.current_rate = $urandom;
        case ($urandom_range(9))
            0:       c.elapsed_ms = '0;
            1:       c.elapsed_ms = 16'hFFFF;
            2:       c.elapsed_ms = ELAPSED_W'($urandom_range(65535));
            default: c.elapsed_ms = ELAPSED_W'($urandom_range(20, 1));
        endcase
        pick = $urandom_range(99);
        if (pick < 58)
            c.kind = KIND_REQUEST;
        else if (pick < 85)
            c.kind = KIND_TICK;
        else if (pick < 95)
            c.kind = KIND_KILL;
        else
            c.kind = KIND_UNUSED;
        return c;
    endfunction

    // Hold until every word is taken and answered, then let silent work finish
    task automatic wait_drained();
        while (command_backlog.size() != 0 || start || verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        if (idx == CFG_MAX_RATE)
            limit_rate = value;
        else
            share_on = value[0];
        cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(logic [DATA_W-1:0] rate, logic share);
        wait_drained();
        write_register(CFG_MAX_RATE, rate);
        write_register(CFG_SHARE, {31'b0, share});
        settings_used++;
    endtask

    // Command driver: record the accepted word, then offer the next one
    always @(posedge clk)
    begin : drive_commands
        command_t next_cmd;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                apply_command(cmd_word);
                commands_taken++;
            end
            if (!start || !busy)
            begin
                if (command_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    next_cmd = command_backlog[0];
                    command_backlog.delete(0);
                    cmd_word <= next_cmd;
                    start    <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each strobed result with the oldest one owed
    always @(posedge clk)
    begin : check_results
        verdict_t owed;
        if (rst_n && result_valid)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("result with none owed: verdict %0d to %0d bytes %0d",
                       verdict, granted_to, granted_bytes);
                mismatch_count++;
            end
            else
            begin
                owed = verdicts_due[0];
                verdicts_due.delete(0);
                results_checked++;
                if (owed.verdict == VERDICT_GRANT)
                    grants_checked++;
                if (verdict !== owed.verdict)
                begin
                    $error("verdict: expected %0d, actual %0d", owed.verdict, verdict);
                    mismatch_count++;
                end
                if (granted_to !== owed.who)
                begin
                    $error("granted_to: expected %0d, actual %0d", owed.who, granted_to);
                    mismatch_count++;
                end
                if (granted_bytes !== owed.bytes)
                begin
                    $error("granted_bytes: expected %0d, actual %0d", owed.bytes,
                           granted_bytes);
                    mismatch_count++;
                end
                if (last !== owed.last)
                begin
                    $error("last: expected %0d, actual %0d", owed.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        command_t odd_cmd;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Unlimited rate: everything passes, empty tick, unused code dropped
        set_limits('0, 1'b0);
        command_backlog.push_back(request_cmd('0, '0, '0));
        command_backlog.push_back(request_cmd(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        command_backlog.push_back(tick_cmd(16'hFFFF));
        odd_cmd = '1;
        odd_cmd.kind = KIND_UNUSED;
        command_backlog.push_back(odd_cmd);

        // One byte per ms: share boundary, zero budget, partial and zero-byte grants
        set_limits(32'd1000, 1'b1);
        command_backlog.push_back(request_cmd(8'd9, 32'd40, 32'd749));
        command_backlog.push_back(request_cmd(8'd1, 32'd5, 32'd750));
        command_backlog.push_back(request_cmd(8'd2, '0, 32'hFFFF_FFFF));
        command_backlog.push_back(tick_cmd('0));
        command_backlog.push_back(tick_cmd(16'd3));
        command_backlog.push_back(tick_cmd(16'd4));
        // Fill the queue, overflow it, then kill one requester
        for (int i = 0; i < QDEPTH + 1; i++)
            command_backlog.push_back(request_cmd(ID_W'(16 + i), DATA_W'(3 * i), 32'hFFFF_FFFF));
        command_backlog.push_back(kill_cmd(8'd20));

        // Rate back to zero: the next tick releases the whole queue
        set_limits('0, 1'b1);
        command_backlog.push_back(tick_cmd(16'd7));

        // Random phases over a spread of settings, extremes among them
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       set_limits(32'd250000, 1'b0);
                1:       set_limits(32'd1000, 1'b1);
                2:       set_limits(32'hFFFF_FFFF, 1'b0);
                3:       set_limits(32'd1, 1'b0);
                4:       set_limits($urandom, 1'b1);
                5:       set_limits('0, 1'b0);
                6:       set_limits(32'd50000, 1'b1);
                default: set_limits(32'hFFFF_FFFF, 1'b1);
            endcase
            idle_pct = (p == 3) ? 0 : 21;
            for (int i = 0; i < PHASE_WORDS; i++)
                command_backlog.push_back(random_command());
        end

        wait_drained();
        $display("Run covered %0d command words under %0d register settings;",
                 commands_taken, settings_used);
        $display("%0d results checked, %0d of them grants.", results_checked, grants_checked);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog well past the slowest legal run
    initial
    begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ byte_rate_limiter_queue_core.f @@
sv/brlq_pkg.sv
sv/brlq_div.sv
sv/brlq_mem.sv
sv/byte_rate_limiter_queue_core.sv
bench/testbench.sv
